@@ hw/rtl/drm_pkg.sv @@
package drm_pkg;

    localparam int VERTEX_W = 4;
    localparam int OPCODE_W = 2;
    localparam int ARC_W    = 9;
    localparam int VCOUNT_W = 5;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 5'd16;
    localparam logic [APB_AW-1:0]   ADDR_VERTEX_COUNT = 3'd0;

    typedef enum logic [OPCODE_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_QUERY  = 2'd2,
        OP_SPARE  = 2'd3
    } drm_op_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic step;
        logic finish;
    } drm_cmd_t;

    typedef struct packed {
        logic query_go;
        logic search_done;
    } drm_sts_t;

endpackage

@@ hw/rtl/drm_ctrl.sv @@
module drm_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  logic            m_ready,
    input  drm_pkg::drm_sts_t sts,
    output drm_pkg::drm_cmd_t cmd
);
    import drm_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SEARCH,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        cmd.load   = 1'b0;
        cmd.exec   = 1'b0;
        cmd.step   = 1'b0;
        cmd.finish = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = sts.query_go ? ST_SEARCH : ST_FINISH;
            end
            ST_SEARCH: begin
                cmd.step = 1'b1;
                if (sts.search_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        if (cmd.finish) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

@@ hw/rtl/drm_datapath.sv @@
module drm_datapath #(
    parameter int MAX_VERTICES = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  drm_pkg::drm_cmd_t             cmd,
    output drm_pkg::drm_sts_t             sts,
    input  logic [drm_pkg::OPCODE_W-1:0]  s_opcode,
    input  logic [drm_pkg::VERTEX_W-1:0]  s_src_vertex,
    input  logic [drm_pkg::VERTEX_W-1:0]  s_dst_vertex,
    input  logic [drm_pkg::VCOUNT_W-1:0]  vertex_count,
    output logic                          m_reachable,
    output logic [drm_pkg::ARC_W-1:0]     m_arc_total,
    output logic                          m_status
);
    import drm_pkg::*;

    localparam int IW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int NW = (CW > VCOUNT_W) ? CW : VCOUNT_W;

    logic [MAX_VERTICES-1:0] rows_reg [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] rows_next [MAX_VERTICES];
    logic [ARC_W-1:0]        arc_count_reg, arc_count_next;
    logic [OPCODE_W-1:0]     op_reg;
    logic [VERTEX_W-1:0]     src_reg, dst_reg;
    logic [MAX_VERTICES-1:0] seen_reg, seen_next;
    logic                    status_reg;
    logic                    query_reg;
    logic                    reach_out_reg;
    logic                    status_out_reg;
    logic [ARC_W-1:0]        arc_out_reg;

    logic [NW-1:0]           vc_ext, n_eff;
    logic [MAX_VERTICES-1:0] live_mask;
    logic [MAX_VERTICES-1:0] expand;
    logic [IW-1:0]           src_idx, dst_idx;
    logic                    in_range;
    logic                    arc_bit;
    logic                    query_go;

    assign vc_ext = NW'(vertex_count);
    assign n_eff  = (vc_ext > NW'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : vc_ext;

    always_comb begin
        for (int i = 0; i < MAX_VERTICES; i++) begin
            live_mask[i] = (NW'(i) < n_eff);
        end
    end

    assign src_idx  = IW'(src_reg);
    assign dst_idx  = IW'(dst_reg);
    assign in_range = (NW'(src_reg) < n_eff) && (NW'(dst_reg) < n_eff);
    assign arc_bit  = rows_reg[src_idx][dst_idx];
    assign query_go = in_range && (op_reg == OP_QUERY);

    // one frontier round over all rows
    always_comb begin
        expand = seen_reg;
        for (int v = 0; v < MAX_VERTICES; v++) begin
            if (seen_reg[v]) begin
                expand = expand | (rows_reg[v] & live_mask);
            end
        end
    end

    always_comb begin
        rows_next      = rows_reg;
        arc_count_next = arc_count_reg;
        if (cmd.exec && in_range) begin
            unique case (op_reg)
                OP_INSERT: begin
                    if (!arc_bit) begin
                        rows_next[src_idx][dst_idx] = 1'b1;
                        arc_count_next = arc_count_reg + ARC_W'(1);
                    end
                end
                OP_REMOVE: begin
                    if (arc_bit) begin
                        rows_next[src_idx][dst_idx] = 1'b0;
                        arc_count_next = arc_count_reg - ARC_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        seen_next = seen_reg;
        if (cmd.exec) begin
            seen_next = MAX_VERTICES'(1) << src_idx;
        end else if (cmd.step) begin
            seen_next = expand;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int v = 0; v < MAX_VERTICES; v++) begin
                rows_reg[v] <= '0;
            end
            arc_count_reg <= '0;
        end else begin
            rows_reg      <= rows_next;
            arc_count_reg <= arc_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        seen_reg <= seen_next;
        if (cmd.load) begin
            op_reg  <= s_opcode;
            src_reg <= s_src_vertex;
            dst_reg <= s_dst_vertex;
        end
        if (cmd.exec) begin
            status_reg <= !in_range && (op_reg != OP_SPARE);
            query_reg  <= query_go;
        end
        if (cmd.finish) begin
            reach_out_reg  <= query_reg && seen_reg[dst_idx];
            status_out_reg <= status_reg;
            arc_out_reg    <= arc_count_reg;
        end
    end

    assign sts.query_go    = query_go;
    assign sts.search_done = (expand == seen_reg);

    assign m_reachable = reach_out_reg;
    assign m_arc_total = arc_out_reg;
    assign m_status    = status_out_reg;

endmodule

@@ hw/rtl/digraph_reachability_matrix_unit.sv @@
// insert, remove and ignored items go from input beat to output beat through EXEC and FINISH
// queries add one SEARCH step per frontier round, at most vertex_count rounds
// a new beat is taken only in IDLE, once the last one has finished; a held output stalls input
// the frontier loop over the adjacency rows sets the query time
// reset (aresetn low, synchronous): all arcs cleared, arc count zero, vertex_count 16
module digraph_reachability_matrix_unit #(
    parameter int MAX_VERTICES = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [drm_pkg::OPCODE_W-1:0]  s_opcode,
    input  logic [drm_pkg::VERTEX_W-1:0]  s_src_vertex,
    input  logic [drm_pkg::VERTEX_W-1:0]  s_dst_vertex,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_reachable,
    output logic [drm_pkg::ARC_W-1:0]     m_arc_total,
    output logic                          m_status,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [drm_pkg::APB_AW-1:0]    paddr,
    input  logic [drm_pkg::APB_DW-1:0]    pwdata,
    output logic [drm_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);
    import drm_pkg::*;

    logic [VCOUNT_W-1:0] vertex_count_reg, vertex_count_next;
    drm_cmd_t            cmd;
    drm_sts_t            sts;
    logic                cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr == ADDR_VERTEX_COUNT);

    assign vertex_count_next = cfg_write ? pwdata[VCOUNT_W-1:0] : vertex_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vertex_count_reg <= VCOUNT_RESET;
        end else begin
            vertex_count_reg <= vertex_count_next;
        end
    end

    assign prdata = (paddr == ADDR_VERTEX_COUNT) ? APB_DW'(vertex_count_reg) : '0;

    drm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    drm_datapath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .s_opcode     (s_opcode),
        .s_src_vertex (s_src_vertex),
        .s_dst_vertex (s_dst_vertex),
        .vertex_count (vertex_count_reg),
        .m_reachable  (m_reachable),
        .m_arc_total  (m_arc_total),
        .m_status     (m_status)
    );

endmodule
